/* rtl/mspt_pkg.sv */
// Package for the multi-slot pin pulse timer: action and report codes,
// slot entry and result word types, and fixed field widths.
// No dependencies.
package mspt_pkg;

    // Fixed field widths
    localparam int PIN_W     = 6;
    localparam int DUR_W     = 31;
    localparam int TIME_W    = 32;
    localparam int MASK_W    = 40;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 8;

    // Writable pins after reset: 0, 2, 4, 5 and 13 to 33
    localparam logic [MASK_W-1:0] MASK_RESET = 40'h3_FFFF_E035;

    typedef enum logic [1:0] {
        ACT_START    = 2'd0,
        ACT_CANCEL   = 2'd1,
        ACT_TICK     = 2'd2,
        ACT_STOP_ALL = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_PULSE   = 2'd0,
        KIND_RESTORE = 2'd1,
        KIND_BUSY    = 2'd2,
        KIND_INVALID = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } seq_state_t;

    // One slot of the pulse table
    typedef struct packed {
        logic [PIN_W-1:0]  pin;
        logic [TIME_W-1:0] deadline;
        logic              saved;
    } slot_entry_t;

    // One result word towards the output register
    typedef struct packed {
        kind_t            kind;
        logic [PIN_W-1:0] pin;
        logic             drive;
        logic             saved;
        logic             last;
    } result_t;

endpackage

/* rtl/multi_slot_pin_pulse_timer_core.sv */
// Top level of the multi-slot pin pulse timer.
// Depends on mspt_pkg, mspt_seq, mspt_slot_mem and mspt_out_buf.
//
// Takes one request word at a time. Start, cancel and tick walk the slot
// memory one entry per cycle through its single read port, except while a
// tick waits for the result side to take a restore word; the next word may
// enter once the walk and its result are done. An invalid start skips the
// walk, and stop all is done as it is taken. A tick passes each restore word
// on as soon as the next expired slot is found, and the final one when the
// walk is over, so tlast marks it. Results wait in an output register, so
// a new request is taken while the last result of the previous one is unread.
module multi_slot_pin_pulse_timer_core
#(
    parameter int SLOTS     = 8,
    parameter int PIN_COUNT = 40
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mspt_pkg::MASK_W-1:0]     cfg_wr_data,    // writable_pin_mask
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mspt_pkg::S_TDATA_W-1:0]  s_tdata,        // pin, level, duration_ms,
                                                            // pin_level_now, now_ms, pad
    input  logic [1:0]                      s_tuser,        // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mspt_pkg::M_TDATA_W-1:0]  m_tdata,        // drive_pin, drive_level,
                                                            // saved_level
    output logic [1:0]                      m_tuser,        // kind
    output logic                            m_tlast
);
    import mspt_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    logic              mem_re;
    logic [SLOT_W-1:0] mem_raddr;
    slot_entry_t       mem_rdata;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    slot_entry_t       mem_wdata;
    logic              res_push;
    result_t           res_data;
    logic              res_ready;

    mspt_seq
    #(
        .SLOTS     (SLOTS),
        .PIN_COUNT (PIN_COUNT),
        .SLOT_W    (SLOT_W),
        .CNT_W     (CNT_W)
    )
    u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .res_push    (res_push),
        .res_data    (res_data),
        .res_ready   (res_ready)
    );

    mspt_slot_mem
    #(
        .DEPTH  (SLOTS),
        .ADDR_W (SLOT_W)
    )
    u_slot_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mspt_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .ready     (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* rtl/mspt_slot_mem.sv */
// Slot table memory: one write port, one read port, registered read data.
// Depends on mspt_pkg for the slot entry type.
module mspt_slot_mem
#(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
)
(
    input  logic                  clk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  mspt_pkg::slot_entry_t wdata,
    input  logic                  re,
    input  logic [ADDR_W-1:0]     raddr,
    output mspt_pkg::slot_entry_t rdata
);
    import mspt_pkg::*;

    slot_entry_t ram [DEPTH];
    slot_entry_t rdata_reg;

    // Write the entry; read data is registered and held while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= ram[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/mspt_out_buf.sv */
// Output register for result words on the master stream side.
// Depends on mspt_pkg for the result word type.
module mspt_out_buf
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  mspt_pkg::result_t               push_data,
    output logic                            ready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mspt_pkg::M_TDATA_W-1:0]  m_tdata,   // drive_pin, drive_level, saved_level
    output logic [1:0]                      m_tuser,   // kind
    output logic                            m_tlast
);
    import mspt_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    result_t data_reg;

    // Free when empty or when the held word leaves this cycle
    assign ready    = !vld_reg || m_tready;
    assign vld_next = push || (vld_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Load a new word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= push_data;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {data_reg.saved, data_reg.drive, data_reg.pin};
    assign m_tuser  = data_reg.kind;
    assign m_tlast  = data_reg.last;

endmodule

/* rtl/mspt_seq.sv */
// Sequencer: takes requests, scans the slot memory one entry a cycle unless
// a tick is held by the result side, holds the active bits and the mask, and
// writes back the chosen slot. Depends on mspt_pkg.
module mspt_seq
#(
    parameter int SLOTS     = 8,
    parameter int PIN_COUNT = 40,
    parameter int SLOT_W    = 3,
    parameter int CNT_W     = 4
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mspt_pkg::MASK_W-1:0]     cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mspt_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]                      s_tuser,
    output logic                            mem_re,
    output logic [SLOT_W-1:0]               mem_raddr,
    input  mspt_pkg::slot_entry_t           mem_rdata,
    output logic                            mem_we,
    output logic [SLOT_W-1:0]               mem_waddr,
    output mspt_pkg::slot_entry_t           mem_wdata,
    output logic                            res_push,
    output mspt_pkg::result_t               res_data,
    input  logic                            res_ready
);
    import mspt_pkg::*;

    // Control state
    seq_state_t              state_reg, state_next;
    logic [MASK_W-1:0]       mask_reg;
    logic [SLOTS-1:0]        active_reg, active_next;
    logic [CNT_W-1:0]        rd_cnt_reg, rd_cnt_next;
    logic                    eval_vld_reg, eval_vld_next;
    logic                    match_vld_reg, match_vld_next;
    logic                    free_vld_reg, free_vld_next;
    logic                    pend_vld_reg, pend_vld_next;
    logic                    invalid_reg, invalid_next;

    // Held request and scan results
    action_t                 act_reg, act_next;
    logic [PIN_W-1:0]        pin_reg, pin_next;
    logic                    level_reg, level_next;
    logic [DUR_W-1:0]        dur_reg, dur_next;
    logic                    now_lvl_reg, now_lvl_next;
    logic [TIME_W-1:0]       now_reg, now_next;
    logic [SLOT_W-1:0]       eval_idx_reg, eval_idx_next;
    logic [SLOT_W-1:0]       match_idx_reg, match_idx_next;
    logic                    match_saved_reg, match_saved_next;
    logic [SLOT_W-1:0]       free_idx_reg, free_idx_next;
    logic [PIN_W-1:0]        pend_pin_reg, pend_pin_next;
    logic                    pend_lvl_reg, pend_lvl_next;

    // Request decode and per-slot tests
    action_t                 in_act;
    logic [PIN_W-1:0]        in_pin;
    logic [DUR_W-1:0]        in_dur;
    logic [63:0]             mask_wide;
    logic                    in_invalid;
    logic                    ev_act;
    logic                    ev_hit;
    logic [TIME_W-1:0]       ev_diff;
    logic                    ev_expired;
    logic                    stall;
    logic [SLOT_W-1:0]       use_idx;
    logic                    use_saved;

    assign in_act     = action_t'(s_tuser);
    assign in_pin     = s_tdata[5:0];
    assign in_dur     = s_tdata[37:7];
    assign mask_wide  = {{(64-MASK_W){1'b0}}, mask_reg};
    assign in_invalid = (in_dur == '0)
                     || ({1'b0, in_pin} >= 7'(PIN_COUNT))
                     || !mask_wide[in_pin];

    assign ev_act     = active_reg[eval_idx_reg];
    assign ev_hit     = (mem_rdata.pin == pin_reg);
    assign ev_diff    = now_reg - mem_rdata.deadline;
    assign ev_expired = !ev_diff[TIME_W-1];

    assign use_idx    = match_vld_reg ? match_idx_reg : free_idx_reg;
    assign use_saved  = match_vld_reg ? match_saved_reg : now_lvl_reg;

    // Next state, memory access and result generation
    always_comb
    begin
        state_next       = state_reg;
        active_next      = active_reg;
        rd_cnt_next      = rd_cnt_reg;
        eval_vld_next    = eval_vld_reg;
        match_vld_next   = match_vld_reg;
        free_vld_next    = free_vld_reg;
        pend_vld_next    = pend_vld_reg;
        invalid_next     = invalid_reg;
        act_next         = act_reg;
        pin_next         = pin_reg;
        level_next       = level_reg;
        dur_next         = dur_reg;
        now_lvl_next     = now_lvl_reg;
        now_next         = now_reg;
        eval_idx_next    = eval_idx_reg;
        match_idx_next   = match_idx_reg;
        match_saved_next = match_saved_reg;
        free_idx_next    = free_idx_reg;
        pend_pin_next    = pend_pin_reg;
        pend_lvl_next    = pend_lvl_reg;

        s_tready         = 1'b0;
        stall            = 1'b0;
        mem_re           = 1'b0;
        mem_raddr        = rd_cnt_reg[SLOT_W-1:0];
        mem_we           = 1'b0;
        mem_waddr        = use_idx;
        mem_wdata.pin      = pin_reg;
        mem_wdata.deadline = now_reg + {1'b0, dur_reg};
        mem_wdata.saved    = use_saved;
        res_push         = 1'b0;
        res_data.kind    = KIND_PULSE;
        res_data.pin     = pin_reg;
        res_data.drive   = 1'b0;
        res_data.saved   = 1'b0;
        res_data.last    = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    act_next       = in_act;
                    pin_next       = in_pin;
                    level_next     = s_tdata[6];
                    dur_next       = in_dur;
                    now_lvl_next   = s_tdata[38];
                    now_next       = s_tdata[70:39];
                    rd_cnt_next    = '0;
                    eval_vld_next  = 1'b0;
                    match_vld_next = 1'b0;
                    free_vld_next  = 1'b0;
                    pend_vld_next  = 1'b0;
                    invalid_next   = 1'b0;
                    if (in_act == ACT_STOP_ALL)
                    begin
                        active_next = '0;
                    end
                    else if (in_act == ACT_START && in_invalid)
                    begin
                        invalid_next = 1'b1;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Evaluate the entry from the last issued read
                if (eval_vld_reg)
                begin
                    case (act_reg)
                        ACT_START:
                        begin
                            if (ev_act && ev_hit && !match_vld_reg)
                            begin
                                match_vld_next   = 1'b1;
                                match_idx_next   = eval_idx_reg;
                                match_saved_next = mem_rdata.saved;
                            end
                            if (!ev_act && !free_vld_reg)
                            begin
                                free_vld_next = 1'b1;
                                free_idx_next = eval_idx_reg;
                            end
                        end
                        ACT_CANCEL:
                        begin
                            if (ev_act && ev_hit)
                            begin
                                active_next[eval_idx_reg] = 1'b0;
                            end
                        end
                        ACT_TICK:
                        begin
                            if (ev_act && ev_expired)
                            begin
                                // Hand on the earlier restore; this one may be the last
                                if (pend_vld_reg)
                                begin
                                    if (res_ready)
                                    begin
                                        res_push       = 1'b1;
                                        res_data.kind  = KIND_RESTORE;
                                        res_data.pin   = pend_pin_reg;
                                        res_data.drive = pend_lvl_reg;
                                        res_data.saved = pend_lvl_reg;
                                        res_data.last  = 1'b0;
                                    end
                                    else
                                    begin
                                        stall = 1'b1;
                                    end
                                end
                                if (!stall)
                                begin
                                    pend_vld_next             = 1'b1;
                                    pend_pin_next             = mem_rdata.pin;
                                    pend_lvl_next             = mem_rdata.saved;
                                    active_next[eval_idx_reg] = 1'b0;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                // Issue the next read unless held
                if (!stall)
                begin
                    eval_vld_next = 1'b0;
                    if (rd_cnt_reg != CNT_W'(SLOTS))
                    begin
                        mem_re        = 1'b1;
                        eval_vld_next = 1'b1;
                        eval_idx_next = rd_cnt_reg[SLOT_W-1:0];
                        rd_cnt_next   = rd_cnt_reg + 1'b1;
                    end
                    else if (!eval_vld_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                case (act_reg)
                    ACT_START:
                    begin
                        if (res_ready)
                        begin
                            res_push   = 1'b1;
                            state_next = ST_IDLE;
                            if (invalid_reg)
                            begin
                                res_data.kind = KIND_INVALID;
                            end
                            else if (match_vld_reg || free_vld_reg)
                            begin
                                res_data.kind        = KIND_PULSE;
                                res_data.drive       = level_reg;
                                res_data.saved       = use_saved;
                                mem_we               = 1'b1;
                                active_next[use_idx] = 1'b1;
                            end
                            else
                            begin
                                res_data.kind = KIND_BUSY;
                            end
                        end
                    end
                    ACT_TICK:
                    begin
                        if (!pend_vld_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (res_ready)
                        begin
                            res_push       = 1'b1;
                            res_data.kind  = KIND_RESTORE;
                            res_data.pin   = pend_pin_reg;
                            res_data.drive = pend_lvl_reg;
                            res_data.saved = pend_lvl_reg;
                            res_data.last  = 1'b1;
                            state_next     = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mask_reg      <= MASK_RESET;
            active_reg    <= '0;
            rd_cnt_reg    <= '0;
            eval_vld_reg  <= 1'b0;
            match_vld_reg <= 1'b0;
            free_vld_reg  <= 1'b0;
            pend_vld_reg  <= 1'b0;
            invalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            rd_cnt_reg    <= rd_cnt_next;
            eval_vld_reg  <= eval_vld_next;
            match_vld_reg <= match_vld_next;
            free_vld_reg  <= free_vld_next;
            pend_vld_reg  <= pend_vld_next;
            invalid_reg   <= invalid_next;
            if (cfg_wr_en)
            begin
                mask_reg <= cfg_wr_data;
            end
        end
    end

    // Hold request fields and scan results
    always_ff @(posedge clk)
    begin
        act_reg         <= act_next;
        pin_reg         <= pin_next;
        level_reg       <= level_next;
        dur_reg         <= dur_next;
        now_lvl_reg     <= now_lvl_next;
        now_reg         <= now_next;
        eval_idx_reg    <= eval_idx_next;
        match_idx_reg   <= match_idx_next;
        match_saved_reg <= match_saved_next;
        free_idx_reg    <= free_idx_next;
        pend_pin_reg    <= pend_pin_next;
        pend_lvl_reg    <= pend_lvl_next;
    end

endmodule

/* rtl/mspt_checker.sv */
// Port-level checks on the result stream of the pulse timer, and the bind
// that attaches them to the top level. Depends on mspt_pkg.
module mspt_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mspt_pkg::M_TDATA_W-1:0]  m_tdata,   // drive_pin, drive_level, saved_level
    input  logic [1:0]                      m_tuser,   // kind
    input  logic                            m_tlast
);
    import mspt_pkg::*;

    // Hold a stalled word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                 && $stable(m_tuser) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // Start, busy and invalid reports are single words
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != KIND_RESTORE) |-> m_tlast)
        else $error("non-restore report without tlast");

    // Busy and invalid reports carry zero levels
    a_reject_lvl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == KIND_BUSY) || (m_tuser == KIND_INVALID))
        |-> (m_tdata[7:6] == 2'b00))
        else $error("rejected start carries a level");

    // A restore drives the saved level
    a_restore_lvl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_RESTORE) |-> (m_tdata[6] == m_tdata[7]))
        else $error("restore level differs from saved level");

endmodule

bind multi_slot_pin_pulse_timer_core mspt_checker u_mspt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
